[rtl/lfa32_pkg.sv]
// ----------------------------------------------------------------------------
// lfa32_pkg
// Shared types, constants and helpers for the letter-filtered Adler-32 block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfa32_pkg;

  // adler-32 modulus and sum start values
  localparam int unsigned MODULUS_VAL = 65521;
  localparam logic [15:0] MODULUS     = 16'(MODULUS_VAL);
  localparam logic [15:0] LOW_START   = 16'd1;
  localparam logic [15:0] HIGH_START  = 16'd0;

  // ascii codes for the letter ranges
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5a;
  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] LOWER_Z  = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef logic [15:0] sum_t;

  // one step handed from the input stage to the accumulator
  typedef struct packed {
    logic       take;
    logic       last;
    logic [7:0] data;
  } step_t;

  // letter test and upper-case fold of one byte
  typedef struct packed {
    logic       is_letter;
    logic [7:0] folded;
  } letter_t;

  function automatic letter_t fold_letter(input logic [7:0] ch);
    letter_t r;
    logic    up;
    logic    lo;
    up = (ch >= UPPER_A) && (ch <= UPPER_Z);
    lo = (ch >= LOWER_A) && (ch <= LOWER_Z);
    r.is_letter = up || lo;
    r.folded    = lo ? (ch - CASE_GAP) : ch;
    return r;
  endfunction

  // (x + y) mod MODULUS for x, y already below MODULUS
  function automatic sum_t add_mod(input sum_t x, input sum_t y);
    logic [16:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/lfa32_if.sv]
// ----------------------------------------------------------------------------
// lfa32 channel interfaces
// Valid/ready channels for the byte input and the checksum output.
// ----------------------------------------------------------------------------
`default_nettype none

// byte input channel
interface lfa32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// checksum output channel
interface lfa32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

`default_nettype wire

[rtl/lfa32_accum.sv]
// ----------------------------------------------------------------------------
// lfa32_accum
// Running low/high sums: folds one letter per step, restarts on last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lfa32_accum
  import lfa32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire step_t       step,
  output      logic [31:0] checksum
);

  sum_t    low_sum;
  sum_t    high_sum;
  sum_t    low_next;
  sum_t    high_next;
  sum_t    low_upd;
  sum_t    high_upd;
  letter_t let_info;

  // fold the letter into both sums, two chained modular adds
  always_comb begin
    let_info = fold_letter(step.data);
    low_upd  = add_mod(low_sum, {8'd0, let_info.folded});
    high_upd = add_mod(high_sum, low_upd);
    if (let_info.is_letter) begin
      low_next  = low_upd;
      high_next = high_upd;
    end else begin
      low_next  = low_sum;
      high_next = high_sum;
    end
  end

  // checksum of the sequence including this step
  assign checksum = {high_next, low_next};

  // sum registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum  <= LOW_START;
      high_sum <= HIGH_START;
    end else if (step.take) begin
      if (step.last) begin
        low_sum  <= LOW_START;
        high_sum <= HIGH_START;
      end else begin
        low_sum  <= low_next;
        high_sum <= high_next;
      end
    end
  end

  // sums stay fully reduced
  assert property (@(posedge clk) disable iff (rst) low_sum < MODULUS)
    else $error("low sum out of range");
  assert property (@(posedge clk) disable iff (rst) high_sum < MODULUS)
    else $error("high sum out of range");
  // a finished sequence restarts the sums
  assert property (@(posedge clk) disable iff (rst)
    step.take && step.last |=> low_sum == LOW_START && high_sum == HIGH_START)
    else $error("sums not restarted after last byte");
  // sums hold while no step is taken
  assert property (@(posedge clk) disable iff (rst)
    !step.take |=> $stable(low_sum) && $stable(high_sum))
    else $error("sums changed without a step");

endmodule

`default_nettype wire

[rtl/letter_filtered_adler32.sv]
// ----------------------------------------------------------------------------
// letter_filtered_adler32
// Adler-32 style checksum over the ASCII letters of a byte sequence.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : one byte per transaction, last_byte marks the end of a sequence.
//            Letters are folded to upper case and summed; other bytes are
//            ignored, though a non-letter last byte still ends the sequence.
//   result : one transaction per sequence, checksum = {high_sum, low_sum}.
// Timing:
//   a byte is captured in the input register, then folded into the sums as
//   it leaves that register and, if it is the last one, the checksum is
//   loaded into the output register as it leaves and drives result valid.
//   One byte per cycle is sustained while no last byte waits on a held result;
//   the combinational sum update between the sum registers is the loop that
//   sets that rate.
// Reset (rst, synchronous): both registers empty, low sum 1, high sum 0.
// Stall: while result is held, non-last bytes keep flowing; a last byte
//   waits in the input register until the output register frees up, and
//   bytes stops accepting only while that byte waits.
// ----------------------------------------------------------------------------
`default_nettype none

module letter_filtered_adler32
  import lfa32_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lfa32_in_if.sink    bytes,
  lfa32_out_if.source result
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        out_valid;
  logic [31:0] out_checksum;
  logic        out_free;
  logic        s1_advance;
  logic [31:0] sum_checksum;
  step_t       step;

  // stage advance control
  assign out_free     = !out_valid || result.ready;
  assign s1_advance   = s1_valid && (!s1_last || out_free);
  assign bytes.ready  = !s1_valid || s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      s1_byte <= bytes.data_byte;
      s1_last <= bytes.last_byte;
    end
  end

  // sum accumulator
  assign step.take = s1_advance;
  assign step.last = s1_last;
  assign step.data = s1_byte;

  lfa32_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .checksum (sum_checksum)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_advance && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      out_checksum <= sum_checksum;
    end
  end

  assign result.valid    = out_valid;
  assign result.checksum = out_checksum;

  // a last byte blocked by a stalled result stays in the input register
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && !result.ready |=> s1_valid && s1_last)
    else $error("last byte lost while result stalled");
  // an empty input register always takes a byte
  assert property (@(posedge clk) disable iff (rst) !s1_valid |-> bytes.ready)
    else $error("input stalled while empty");
  // a result appears only after a last byte was folded in
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_advance && s1_last))
    else $error("result without a last byte");

endmodule

`default_nettype wire
